/* sv/generational_handle_table_top_macros.svh */
// Assertion macros for the handle table
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define GHT_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("check failed");
`define GHT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("check failed");
`else
`define GHT_ASSERT_IMPL(label, clk, rst, a, c)
`define GHT_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

/* sv/ght_pkg.sv */
// Shared types and constants for the handle table
`default_nettype none
package ght_pkg;
  localparam int ModelSlots = 16;
  localparam int SessSlots = 32;
  localparam int MIdxW = $clog2(ModelSlots);
  localparam int SIdxW = $clog2(SessSlots);

  localparam logic [2:0] ACT_REGISTER = 3'd0;
  localparam logic [2:0] ACT_CREATE = 3'd1;
  localparam logic [2:0] ACT_INVOKE = 3'd2;
  localparam logic [2:0] ACT_COMPLETE = 3'd3;
  localparam logic [2:0] ACT_DESTROY = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BADARG = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_STALE = 2'd3;

  localparam logic [1:0] MODE_DORMANT = 2'd0;
  localparam logic [1:0] MODE_ACTIVE = 2'd1;
  localparam logic [1:0] MODE_STOPPED = 2'd2;

  localparam logic [31:0] GenMax = 32'hffff_ffff;

  typedef struct packed {
    logic [2:0] action;
    logic [47:0] handle;
    logic [47:0] budget;
    logic [3:0] task_kind;
    logic [31:0] owner;
    logic [31:0] rights;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [47:0] new_handle;
    logic woke_waiters;
    logic [31:0] use_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request, start lookups
    logic commit;   // apply table update and form result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lookup_done;
  } stat_t;
endpackage
`default_nettype wire

/* sv/ght_ctrl.sv */
// Controller sequencing one request through the datapath
`default_nettype none
module ght_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  output ght_pkg::cmd_t cmd,
  input  ght_pkg::stat_t stat
);
  import ght_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat.lookup_done) begin
          cmd.commit = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

/* sv/ght_datapath.sv */
// Slot tables, free-slot scan and result formation
`default_nettype none
module ght_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  ght_pkg::cmd_t cmd,
  output ght_pkg::stat_t stat,
  input  ght_pkg::req_t req,
  output ght_pkg::rsp_t result,
  output logic done
);
  import ght_pkg::*;

  logic [ModelSlots-1:0] model_live;
  logic [31:0] model_gen [ModelSlots];
  logic [1:0] model_mode [ModelSlots];
  logic [47:0] model_budget [ModelSlots];
  logic [31:0] model_calls [ModelSlots];
  logic [SessSlots-1:0] sess_live;
  logic [31:0] sess_gen [SessSlots];
  logic [1:0] sess_mode [SessSlots];
  logic [3:0] sess_kind [SessSlots];
  logic [47:0] sess_model [SessSlots];
  logic [31:0] sess_owner [SessSlots];
  logic [31:0] sess_rights [SessSlots];

  req_t r;
  // lookup results registered in the LOOK cycle
  logic m_free_ok, s_free_ok, m_hit, s_hit;
  logic [MIdxW-1:0] m_free, m_hidx;
  logic [SIdxW-1:0] s_free, s_hidx;
  logic [31:0] m_free_gen, s_free_gen;
  logic look_wait, look_valid;

  // free-slot search (combinational priority over flop bits)
  logic mf_ok, sf_ok;
  logic [MIdxW-1:0] mf;
  logic [SIdxW-1:0] sf;
  always_comb begin
    mf_ok = 1'b0;
    mf = '0;
    for (int i = ModelSlots - 1; i >= 0; i--) begin
      if (!model_live[i] && model_gen[i] != GenMax) begin
        mf_ok = 1'b1;
        mf = MIdxW'(i);
      end
    end
    sf_ok = 1'b0;
    sf = '0;
    for (int i = SessSlots - 1; i >= 0; i--) begin
      if (!sess_live[i] && sess_gen[i] != GenMax) begin
        sf_ok = 1'b1;
        sf = SIdxW'(i);
      end
    end
  end

  // handle checks on the captured request
  logic [15:0] hslot;
  logic [31:0] hgen;
  logic mh, sh;
  logic [MIdxW-1:0] mhi;
  logic [SIdxW-1:0] shi;
  always_comb begin
    hslot = r.handle[15:0];
    hgen = r.handle[47:16];
    mhi = MIdxW'(hslot - 16'd1);
    shi = SIdxW'(hslot - 16'd1);
    mh = hslot != 16'd0 && hslot <= 16'(ModelSlots) && hgen != 32'd0
         && model_live[mhi] && model_gen[mhi] == hgen;
    sh = hslot != 16'd0 && hslot <= 16'(SessSlots) && hgen != 32'd0
         && sess_live[shi] && sess_gen[shi] == hgen;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
    m_free_ok <= mf_ok;
    s_free_ok <= sf_ok;
    m_free <= mf;
    s_free <= sf;
    m_free_gen <= model_gen[mf] + 32'd1;
    s_free_gen <= sess_gen[sf] + 32'd1;
    m_hit <= mh;
    s_hit <= sh;
    m_hidx <= mhi;
    s_hidx <= shi;
  end

  // lookup_done follows load through look_wait and look_valid: lookups, then registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      look_wait <= 1'b0;
      look_valid <= 1'b0;
    end else begin
      look_wait <= cmd.load;
      look_valid <= look_wait;
    end
  end
  assign stat.lookup_done = look_valid;

  // invoke path: linked model slot
  logic [15:0] ms;
  logic ms_ok;
  logic [MIdxW-1:0] mi;
  logic [31:0] calls_next;
  always_comb begin
    ms = sess_model[s_hidx][15:0];
    ms_ok = ms != 16'd0 && ms <= 16'(ModelSlots);
    mi = MIdxW'(ms - 16'd1);
    calls_next = (model_calls[mi] != GenMax) ? model_calls[mi] + 32'd1 : model_calls[mi];
  end

  rsp_t res_next;
  always_comb begin
    res_next = '0;
    unique case (r.action)
      ACT_REGISTER: begin
        if (r.budget == 48'd0) res_next.status = ST_BADARG;
        else if (!m_free_ok) res_next.status = ST_FULL;
        else res_next.new_handle = {m_free_gen, 16'(m_free) + 16'd1};
      end
      ACT_CREATE: begin
        if (r.owner == 32'd0) res_next.status = ST_BADARG;
        else if (!m_hit) res_next.status = ST_STALE;
        else if (!s_free_ok) res_next.status = ST_FULL;
        else res_next.new_handle = {s_free_gen, 16'(s_free) + 16'd1};
      end
      ACT_INVOKE, ACT_COMPLETE, ACT_DESTROY: begin
        if (!s_hit) res_next.status = ST_STALE;
        else if (r.action == ACT_INVOKE) begin
          if (ms_ok) res_next.use_count = calls_next;
        end else res_next.woke_waiters = 1'b1;
      end
      default: res_next.status = ST_BADARG;
    endcase
  end

  logic ok;
  assign ok = (res_next.status == ST_OK);

  always_ff @(posedge clk) begin
    if (cmd.commit) result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      model_live <= '0;
      sess_live <= '0;
      for (int i = 0; i < ModelSlots; i++) model_gen[i] <= '0;
      for (int i = 0; i < SessSlots; i++) sess_gen[i] <= '0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit && ok) begin
        unique case (r.action)
          ACT_REGISTER: begin
            model_live[m_free] <= 1'b1;
            model_gen[m_free] <= m_free_gen;
          end
          ACT_CREATE: begin
            sess_live[s_free] <= 1'b1;
            sess_gen[s_free] <= s_free_gen;
          end
          ACT_DESTROY: sess_live[s_hidx] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // payload stores need no reset
  always_ff @(posedge clk) begin
    if (cmd.commit && ok) begin
      unique case (r.action)
        ACT_REGISTER: begin
          model_mode[m_free] <= MODE_DORMANT;
          model_budget[m_free] <= r.budget;
          model_calls[m_free] <= 32'd0;
        end
        ACT_CREATE: begin
          sess_mode[s_free] <= MODE_DORMANT;
          sess_kind[s_free] <= r.task_kind;
          sess_model[s_free] <= r.handle;
          sess_owner[s_free] <= r.owner;
          sess_rights[s_free] <= r.rights;
        end
        ACT_INVOKE: begin
          sess_mode[s_hidx] <= MODE_ACTIVE;
          if (ms_ok) begin
            model_mode[mi] <= MODE_ACTIVE;
            model_calls[mi] <= calls_next;
          end
        end
        ACT_COMPLETE: sess_mode[s_hidx] <= MODE_DORMANT;
        ACT_DESTROY: sess_mode[s_hidx] <= MODE_STOPPED;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/generational_handle_table_top.sv */
// Top level of the generational handle table
//  channel  | signals              | beat taken when
//  request  | start, busy, req     | start && !busy
//  result   | done, result         | done (one cycle, no stall)
// A request runs through table lookup, registered lookup and commit, then the result beat;
// done is registered from the commit and is high while the controller is in DONE.
// The next request is taken the cycle after done at the earliest.
// Reset clears live bits and generations.
// The receiver cannot stall; done is high for one cycle only, result holds to the next commit.
`default_nettype none
`include "generational_handle_table_top_macros.svh"
module generational_handle_table_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  ght_pkg::req_t req,
  output ght_pkg::rsp_t result,
  output logic done
);
  import ght_pkg::*;
  cmd_t cmd;
  stat_t stat;

  ght_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .stat(stat));
  ght_datapath u_dp (.clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .req(req),
                     .result(result), .done(done));

  `GHT_ASSERT_NEXT(a_load_busy, clk, rst, start && !busy, busy)
  `GHT_ASSERT_IMPL(a_done_busy, clk, rst, done, busy)
  `GHT_ASSERT_IMPL(a_alloc_ok, clk, rst, done && result.new_handle != 48'd0, result.status == ST_OK)
endmodule
`default_nettype wire

/* tb/generational_handle_table_top_test.sv */
// Testbench for the generational handle table: queued requests, predicted results
`default_nettype none
module generational_handle_table_top_test;
  import ght_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  rsp_t result;
  logic done;

  generational_handle_table_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .result(result), .done(done)
  );

  always #10 clk = ~clk;

  // predictor copy of the tables
  logic        m_live [ModelSlots];
  logic [31:0] m_gen [ModelSlots];
  logic [31:0] m_calls [ModelSlots];
  logic        s_live [SessSlots];
  logic [31:0] s_gen [SessSlots];
  logic [47:0] s_model [SessSlots];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int errors = 0;
  bit feeding_done = 0;
  bit hold_for_drain = 0;
  int gap = 0;

  // handles known to be live, used to build well-formed sequences
  logic [47:0] model_handles[$];
  logic [47:0] sess_handles[$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("error at %0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic int lookup(input logic [47:0] h, input bit is_model);
    int s;
    logic [31:0] g;
    s = h[15:0];
    g = h[47:16];
    if (is_model) begin
      if (s == 0 || s > ModelSlots || g == 0) return -1;
      if (!m_live[s-1] || m_gen[s-1] != g) return -1;
    end else begin
      if (s == 0 || s > SessSlots || g == 0) return -1;
      if (!s_live[s-1] || s_gen[s-1] != g) return -1;
    end
    return s - 1;
  endfunction

  function automatic rsp_t predict_table_op(input req_t r);
    rsp_t o;
    int i, ms;
    o = '0;
    o.status = ST_OK;
    case (r.action)
      ACT_REGISTER: begin
        if (r.budget == 0) o.status = ST_BADARG;
        else begin
          i = -1;
          for (int k = 0; k < ModelSlots; k++)
            if (i < 0 && !m_live[k] && m_gen[k] != GenMax) i = k;
          if (i < 0) o.status = ST_FULL;
          else begin
            m_gen[i]++;
            m_live[i] = 1'b1;
            m_calls[i] = '0;
            o.new_handle = {m_gen[i], 16'(i + 1)};
          end
        end
      end
      ACT_CREATE: begin
        if (r.owner == 0) o.status = ST_BADARG;
        else if (lookup(r.handle, 1'b1) < 0) o.status = ST_STALE;
        else begin
          i = -1;
          for (int k = 0; k < SessSlots; k++)
            if (i < 0 && !s_live[k] && s_gen[k] != GenMax) i = k;
          if (i < 0) o.status = ST_FULL;
          else begin
            s_gen[i]++;
            s_live[i] = 1'b1;
            s_model[i] = r.handle;
            o.new_handle = {s_gen[i], 16'(i + 1)};
          end
        end
      end
      ACT_INVOKE, ACT_COMPLETE, ACT_DESTROY: begin
        i = lookup(r.handle, 1'b0);
        if (i < 0) o.status = ST_STALE;
        else if (r.action == ACT_INVOKE) begin
          ms = s_model[i][15:0];
          if (ms != 0 && ms <= ModelSlots) begin
            if (m_calls[ms-1] != GenMax) m_calls[ms-1]++;
            o.use_count = m_calls[ms-1];
          end
        end else begin
          o.woke_waiters = 1'b1;
          if (r.action == ACT_DESTROY) s_live[i] = 1'b0;
        end
      end
      default: o.status = ST_BADARG;
    endcase
    return o;
  endfunction

  // track handles so random traffic hits live entries often
  function automatic void note_handles(input req_t r, input rsp_t o);
    if (o.status != ST_OK) return;
    if (r.action == ACT_REGISTER) model_handles.push_back(o.new_handle);
    else if (r.action == ACT_CREATE) sess_handles.push_back(o.new_handle);
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 9) < 3) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // driver: predict on acceptance, so state stays in step with the block
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rsp_t o;
        o = predict_table_op(req);
        note_handles(req, o);
        expected_rsps.push_back(o);
      end
      if (start && busy) begin
        // hold the beat
      end else if (hold_for_drain) begin
        // release once every expected result has come
        start <= 1'b0;
        if (expected_rsps.size() == 0) hold_for_drain <= 1'b0;
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req <= pending_reqs.pop_front();
        start <= 1'b1;
        gap <= short_or_long_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        report("unexpected result", 64'(result), 64'd0);
      end else begin
        rsp_t w;
        w = expected_rsps.pop_front();
        if (result.status != w.status)
          report("status", 64'(result.status), 64'(w.status));
        if (result.new_handle != w.new_handle)
          report("new_handle", 64'(result.new_handle), 64'(w.new_handle));
        if (result.woke_waiters != w.woke_waiters)
          report("woke_waiters", 64'(result.woke_waiters), 64'(w.woke_waiters));
        if (result.use_count != w.use_count)
          report("use_count", 64'(result.use_count), 64'(w.use_count));
      end
    end
  end

  function automatic req_t mk(input logic [2:0] a, input logic [47:0] h,
                              input logic [47:0] b, input logic [31:0] own);
    req_t r;
    r.action = a;
    r.handle = h;
    r.budget = b;
    r.task_kind = 4'($urandom);
    r.owner = own;
    r.rights = $urandom;
    return r;
  endfunction

  // pick a handle that is likely live; handles are generated blind to acceptance
  function automatic logic [47:0] pick_handle(input bit is_model);
    int n;
    n = is_model ? model_handles.size() : sess_handles.size();
    if (n == 0 || $urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) return rand48();
      return {32'($urandom_range(0, 3)), 16'($urandom_range(0, 40))};
    end
    return is_model ? model_handles[$urandom_range(0, n - 1)]
                    : sess_handles[$urandom_range(0, n - 1)];
  endfunction

  initial begin
    int n;
    for (int k = 0; k < ModelSlots; k++) begin
      m_live[k] = 1'b0;
      m_gen[k] = '0;
      m_calls[k] = '0;
    end
    for (int k = 0; k < SessSlots; k++) begin
      s_live[k] = 1'b0;
      s_gen[k] = '0;
      s_model[k] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: bad arguments, stale handles, unused codes, extremes
    pending_reqs.push_back(mk(ACT_REGISTER, '0, '0, 32'd1));
    pending_reqs.push_back(mk(3'd5, '1, '1, '1));
    pending_reqs.push_back(mk(3'd6, '0, '0, '0));
    pending_reqs.push_back(mk(3'd7, '1, '0, '1));
    pending_reqs.push_back(mk(ACT_CREATE, {32'd1, 16'd1}, '1, '0));
    pending_reqs.push_back(mk(ACT_CREATE, {32'd1, 16'd1}, '1, '1));
    pending_reqs.push_back(mk(ACT_INVOKE, {32'd1, 16'd1}, '0, '1));
    pending_reqs.push_back(mk(ACT_REGISTER, '1, '1, '1));
    pending_reqs.push_back(mk(ACT_REGISTER, '0, 48'd1, '0));
    pending_reqs.push_back(mk(ACT_CREATE, {32'd0, 16'd1}, '0, '1));
    pending_reqs.push_back(mk(ACT_CREATE, {32'd1, 16'd0}, '0, '1));
    pending_reqs.push_back(mk(ACT_CREATE, {32'd1, 16'd17}, '0, '1));
    pending_reqs.push_back(mk(ACT_CREATE, {32'd2, 16'd1}, '0, '1));
    pending_reqs.push_back(mk(ACT_CREATE, {32'd1, 16'd1}, '0, '1));
    pending_reqs.push_back(mk(ACT_INVOKE, {32'd1, 16'd1}, '0, '0));
    pending_reqs.push_back(mk(ACT_INVOKE, {32'd1, 16'd1}, '0, '0));
    pending_reqs.push_back(mk(ACT_COMPLETE, {32'd1, 16'd1}, '0, '0));
    pending_reqs.push_back(mk(ACT_INVOKE, {32'd1, 16'd33}, '0, '0));
    pending_reqs.push_back(mk(ACT_DESTROY, {32'd1, 16'd1}, '0, '0));
    pending_reqs.push_back(mk(ACT_DESTROY, {32'd1, 16'd1}, '0, '0));
    pending_reqs.push_back(mk(ACT_CREATE, {32'd1, 16'd1}, '0, '1));
    pending_reqs.push_back(mk(ACT_COMPLETE, '1, '1, '1));
    // fill the model table past full
    repeat (17) pending_reqs.push_back(mk(ACT_REGISTER, '0, rand48() | 48'd1, '1));

    // drain before random traffic, so the handle lists are current
    wait (pending_reqs.size() == 0);
    hold_for_drain = 1'b1;
    wait (!hold_for_drain);

    // random: mostly sequences on known handles, some noise
    for (n = 0; n < 1950; n++) begin
      req_t r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) r = mk(ACT_REGISTER, rand48(), ($urandom_range(0, 9) == 0) ? '0 : rand48(),
                           $urandom);
      else if (pick < 35) r = mk(ACT_CREATE, pick_handle(1'b1), rand48(),
                                 ($urandom_range(0, 15) == 0) ? '0 : $urandom);
      else if (pick < 65) r = mk(ACT_INVOKE, pick_handle(1'b0), rand48(), $urandom);
      else if (pick < 80) r = mk(ACT_COMPLETE, pick_handle(1'b0), rand48(), $urandom);
      else if (pick < 97) r = mk(ACT_DESTROY, pick_handle(1'b0), rand48(), $urandom);
      else r = mk(3'($urandom_range(5, 7)), rand48(), rand48(), $urandom);
      pending_reqs.push_back(r);
      // let the block catch up so handle picks see recent allocations
      if (pending_reqs.size() > 4) wait (pending_reqs.size() <= 2);
      if (n == 900) begin
        wait (pending_reqs.size() == 0);
        hold_for_drain = 1'b1;
        wait (!hold_for_drain);
      end
    end
    feeding_done = 1'b1;
  end

  initial begin
    wait (feeding_done && pending_reqs.size() == 0 && !start);
    wait (expected_rsps.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("generational_handle_table_top: match");
    end else begin
      $display("generational_handle_table_top: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("generational_handle_table_top: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
